>>> rtl/rpsg_pkg.sv
// Package for the rational phase sine generator.
// Holds the register index codes, divider request type, CORDIC constants and arctangent table.
// No dependencies.
`default_nettype none
package rpsg_pkg;

  typedef enum logic [1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_MODULUS      = 2'd1,
    REG_AMPLITUDE    = 2'd2,
    REG_PHASE_OFFSET = 2'd3
  } rpsg_reg_t;

  localparam int DIV_DW        = 64;
  localparam int DIV_CNT_W     = 7;
  localparam int CORDIC_STAGES = 30;
  localparam int CORDIC_IT_W   = 5;
  localparam int CORDIC_W      = 34;
  localparam int CORDIC_ZW     = 33;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

  typedef struct packed {
    logic                  start;
    logic [31:0]           rem_init;
    logic [DIV_DW-1:0]     dividend;
    logic [DIV_CNT_W-1:0]  steps;
  } rpsg_div_req_t;

  function automatic logic [29:0] rpsg_atan(input logic [CORDIC_IT_W-1:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'h20000000;
      5'd1:  a = 30'h12E4051E;
      5'd2:  a = 30'h09FB385B;
      5'd3:  a = 30'h051111D4;
      5'd4:  a = 30'h028B0D43;
      5'd5:  a = 30'h0145D7E1;
      5'd6:  a = 30'h00A2F61E;
      5'd7:  a = 30'h00517C55;
      5'd8:  a = 30'h0028BE53;
      5'd9:  a = 30'h00145F2F;
      5'd10: a = 30'h000A2F98;
      5'd11: a = 30'h000517CC;
      5'd12: a = 30'h00028BE6;
      5'd13: a = 30'h000145F3;
      5'd14: a = 30'h0000A2FA;
      5'd15: a = 30'h0000517D;
      5'd16: a = 30'h000028BE;
      5'd17: a = 30'h0000145F;
      5'd18: a = 30'h00000A30;
      5'd19: a = 30'h00000518;
      5'd20: a = 30'h0000028C;
      5'd21: a = 30'h00000146;
      5'd22: a = 30'h000000A3;
      5'd23: a = 30'h00000051;
      5'd24: a = 30'h00000029;
      5'd25: a = 30'h00000014;
      5'd26: a = 30'h0000000A;
      5'd27: a = 30'h00000005;
      5'd28: a = 30'h00000003;
      5'd29: a = 30'h00000001;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rpsg_div.sv
// Shared restoring divider: one quotient bit per cycle against a 32-bit divisor.
// Depends on rpsg_pkg for the request type.
`default_nettype none
module rpsg_div
  import rpsg_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rpsg_div_req_t req,
  input  wire logic [31:0]   divisor,
  output logic               done,
  output logic [31:0]        rem,
  output logic [31:0]        quo
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          quo_r, quo_nxt;
  logic [DIV_DW-1:0]    dvd_r, dvd_nxt;
  logic [32:0]          trial;
  logic [32:0]          diff;
  logic                 ge;

  assign trial = {rem_r, dvd_r[DIV_DW-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvd_nxt  = dvd_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = req.rem_init;
      quo_nxt  = '0;
      dvd_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[31:0] : trial[31:0];
      quo_nxt = {quo_r[30:0], ge};
      dvd_nxt = {dvd_r[DIV_DW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

>>> rtl/rpsg_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// Depends on rpsg_pkg for widths, start vector and arctangent table.
`default_nettype none
module rpsg_cordic
  import rpsg_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [29:0]                 z_init,
  output logic                             done,
  output logic signed [CORDIC_W-1:0]       x,
  output logic signed [CORDIC_W-1:0]       y
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CORDIC_IT_W-1:0]        it_r, it_nxt;
  logic signed [CORDIC_W-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic signed [CORDIC_ZW-1:0]   z_r, z_nxt;
  logic signed [CORDIC_W-1:0]    dx, dy;
  logic signed [CORDIC_ZW-1:0]   da;

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign da = signed'({3'b000, rpsg_atan(it_r)});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    it_nxt   = it_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      it_nxt   = '0;
      x_nxt    = CORDIC_X0;
      y_nxt    = '0;
      z_nxt    = signed'({3'b000, z_init});
    end else if (busy_r) begin
      if (!z_r[CORDIC_ZW-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - da;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + da;
      end
      it_nxt = it_r + 1'b1;
      if (it_r == CORDIC_IT_W'(CORDIC_STAGES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    it_r <= it_nxt;
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;

endmodule
`default_nettype wire

>>> rtl/rational_phase_sine_generator.sv
// Rational phase sine generator: top level with sequencer, phase state and output scaling.
// Instantiates rpsg_div and rpsg_cordic; depends on rpsg_pkg.
//
// Each word on the in_ channel (in_tdata bit 0 = restart) yields one word on the out_
// channel holding amplitude * sin(2*pi*(acc/modulus + phase_offset/65536)),
// saturated. The accumulator then advances by phase_step modulo modulus.
// A word is handled in turn by a single bit-serial divider, which reduces the
// accumulator, forms the turn fraction and wraps the next phase, then by a 30-step
// CORDIC that forms the sine, then by the amplitude multiply and the output stage;
// no new word is taken until the last one has been written to the output register.
// in_tready is high only while the sequencer is idle. A finished result waits in
// the output register; while out_tready is low the next word may still be
// accepted and computed, and the block holds before delivering it until the
// output register is free. Reset clears the accumulator, loads the register
// defaults (phase_step 1, modulus 8, amplitude 1390, phase_offset 0) and empties
// the output. Configuration writes are taken at any time and must only occur
// while the block is idle.
`default_nettype none
module rational_phase_sine_generator
  import rpsg_pkg::*;
#(
  parameter int ACC_WIDTH    = 32,
  parameter int SAMPLE_WIDTH = 16,
  parameter int PHASE_BITS   = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [7:0]                            in_tdata,   // [0] restart
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]  out_tdata,  // sample
  input  wire logic                                  cfg_we,
  input  wire logic [1:0]                            cfg_addr,
  input  wire logic [31:0]                           cfg_wdata
);

  localparam int OUT_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int SH     = 46 - SAMPLE_WIDTH;
  localparam int S_W    = CORDIC_W + 1;
  localparam int PROD_W = S_W + 16;
  localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) <<< (SH - 1);
  localparam logic signed [PROD_W-1:0] LIM = (PROD_W'(1) <<< (SAMPLE_WIDTH - 1)) - 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_TURN, S_WRAP, S_ROT, S_MUL, S_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [31:0]                phase_step_r, modulus_r;
  logic [14:0]                amplitude_r;
  logic [15:0]                phase_offset_r;
  logic [ACC_WIDTH-1:0]       phase_acc_r, phase_acc_nxt;
  logic [31:0]                acc_r, acc_nxt;
  logic [31:0]                theta_r, theta_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0]    sample_r, sample_nxt;

  rpsg_div_req_t              div_req;
  logic                       div_done;
  logic [31:0]                div_rem, div_quo, divisor;
  logic                       cor_start, cor_done;
  logic signed [CORDIC_W-1:0] cor_x, cor_y;
  logic signed [S_W-1:0]      sine;
  logic signed [PROD_W-1:0]   smp;
  logic [32:0]                wrap_sum;
  logic [31:0]                turn32;
  logic                       accept;

  assign divisor   = (modulus_r == 32'd0) ? 32'd1 : modulus_r;
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign wrap_sum  = {1'b0, acc_r} + {1'b0, phase_step_r};
  assign turn32    = 32'(div_quo[PHASE_BITS-1:0]) << (32 - PHASE_BITS);

  always_comb begin
    case (theta_r[31:30])
      2'd0:    sine = S_W'(cor_y);
      2'd1:    sine = S_W'(cor_x);
      2'd2:    sine = -S_W'(cor_y);
      default: sine = -S_W'(cor_x);
    endcase
  end

  assign smp = prod_r >>> SH;

  rpsg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (divisor),
    .done    (div_done),
    .rem     (div_rem),
    .quo     (div_quo)
  );

  rpsg_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cor_start),
    .z_init (theta_r[29:0]),
    .done   (cor_done),
    .x      (cor_x),
    .y      (cor_y)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_acc_nxt = phase_acc_r;
    acc_nxt       = acc_r;
    theta_nxt     = theta_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_tready;
    sample_nxt    = sample_r;
    div_req       = '0;
    cor_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          div_req.start    = 1'b1;
          div_req.dividend = 64'(in_tdata[0] ? '0 : phase_acc_r) << (DIV_DW - ACC_WIDTH);
          div_req.steps    = DIV_CNT_W'(ACC_WIDTH);
          state_nxt        = S_RED;
        end
      end
      S_RED: begin
        if (div_done) begin
          acc_nxt          = div_rem;
          div_req.start    = 1'b1;
          div_req.rem_init = div_rem;
          div_req.steps    = DIV_CNT_W'(PHASE_BITS);
          state_nxt        = S_TURN;
        end
      end
      S_TURN: begin
        if (div_done) begin
          theta_nxt        = turn32 + {phase_offset_r, 16'h0000};
          div_req.start    = 1'b1;
          div_req.dividend = {wrap_sum, 31'h0};
          div_req.steps    = DIV_CNT_W'(33);
          state_nxt        = S_WRAP;
        end
      end
      S_WRAP: begin
        if (div_done) begin
          phase_acc_nxt = ACC_WIDTH'(div_rem);
          cor_start     = 1'b1;
          state_nxt     = S_ROT;
        end
      end
      S_ROT: begin
        if (cor_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = signed'({1'b0, amplitude_r}) * sine + RND;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          if (smp > LIM) begin
            sample_nxt = SAMPLE_WIDTH'(LIM);
          end else if (smp < -LIM) begin
            sample_nxt = SAMPLE_WIDTH'(-LIM);
          end else begin
            sample_nxt = SAMPLE_WIDTH'(smp);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_acc_r    <= '0;
      out_valid_r    <= 1'b0;
      phase_step_r   <= 32'd1;
      modulus_r      <= 32'd8;
      amplitude_r    <= 15'd1390;
      phase_offset_r <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      phase_acc_r <= phase_acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (rpsg_reg_t'(cfg_addr))
          REG_PHASE_STEP:   phase_step_r   <= cfg_wdata;
          REG_MODULUS:      modulus_r      <= cfg_wdata;
          REG_AMPLITUDE:    amplitude_r    <= cfg_wdata[14:0];
          REG_PHASE_OFFSET: phase_offset_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
    acc_r    <= acc_nxt;
    theta_r  <= theta_nxt;
    prod_r   <= prod_nxt;
    sample_r <= sample_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(sample_r);

endmodule
`default_nettype wire
